// File: rtl/dirty_rect_present_tracker_assert.svh
// Assertion macros for the dirty rectangle tracker RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef DIRTY_RECT_PRESENT_TRACKER_ASSERT_SVH
`define DIRTY_RECT_PRESENT_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dirty rect tracker: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dirty rect tracker: next-cycle check failed");

`endif

// File: rtl/drpt_pkg.sv
// Shared types, constants and helper functions for the dirty rectangle tracker.
// No dependencies; every other RTL file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package drpt_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = $clog2(MAX_DIM);
    localparam int DIM_REG_W  = 13;
    localparam int RECT_W     = 16;
    localparam int EXT_W      = RECT_W + 2;
    localparam int TICK_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = DIM_REG_W'(640);
    localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = DIM_REG_W'(480);
    localparam logic [TICK_W-1:0]    LIMIT_RESET  = '0;

    typedef enum logic [1:0] {
        CMD_MARK    = 2'd0,
        CMD_FORCE   = 2'd1,
        CMD_PRESENT = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH    = 2'd0,
        REG_SCREEN_HEIGHT   = 2'd1,
        REG_IDLE_FULL_LIMIT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [RECT_W-1:0] rect_x;
        logic signed [RECT_W-1:0] rect_y;
        logic signed [RECT_W-1:0] rect_w;
        logic signed [RECT_W-1:0] rect_h;
        logic [TICK_W-1:0]        tick_count;
    } in_word_t;

    typedef struct packed {
        logic               full_refresh;
        logic [COORD_W-1:0] copy_x0;
        logic [COORD_W-1:0] copy_y0;
        logic [COORD_W-1:0] copy_x1;
        logic [COORD_W-1:0] copy_y1;
    } out_word_t;

    typedef struct packed {
        logic dirty;
        logic force_pending;
    } core_status_t;

    // Largest valid coordinate for a dimension register, with out-of-range
    // values treated as 1 or MAX_DIM.
    function automatic logic [COORD_W-1:0] dim_last(input logic [DIM_REG_W-1:0] r);
        logic [DIM_REG_W-1:0] m1;
        m1 = r - DIM_REG_W'(1);
        if (r == '0) begin
            return '0;
        end else if (r > DIM_REG_W'(MAX_DIM)) begin
            return COORD_W'(MAX_DIM - 1);
        end else begin
            return m1[COORD_W-1:0];
        end
    endfunction

    // Clamp a wide signed coordinate to [0, hi].
    function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [EXT_W-1:0] v,
                                                       input logic [COORD_W-1:0] hi);
        logic signed [EXT_W-1:0] hi_ext;
        hi_ext = $signed({{(EXT_W - COORD_W){1'b0}}, hi});
        if (v < 0) begin
            return '0;
        end else if (v > hi_ext) begin
            return hi;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/dirty_rect_present_tracker.sv
// Top level of the dirty rectangle tracker: input register, output register
// and handshakes around drpt_cfg and drpt_core. Depends on drpt_pkg.
//
//   Port group   Direction  Handshake           Word
//   in           into       in_valid/in_ready   drpt_pkg::in_word_t
//   out          out of     out_valid/out_ready drpt_pkg::out_word_t
//   cfg          into       cfg_wr_en only      index + 32-bit data
//
// One word is taken per cycle unless in_ready is held low; a present's region
// is computed by the core between the input and result registers.
// Mark, force and unknown commands give no word on the output.
// After reset the whole 640x480 screen is dirty and a full refresh is pending.
// A stalled output holds the input register, which then holds in_ready low.
`timescale 1ns / 1ps
`default_nettype none
`include "dirty_rect_present_tracker_assert.svh"

module dirty_rect_present_tracker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire drpt_pkg::in_word_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output drpt_pkg::out_word_t                     out_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [drpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [drpt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    drpt_pkg::in_word_t                s1_word_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    drpt_pkg::out_word_t               out_word_reg;
    logic                              s1_adv;
    logic                              has_result;
    drpt_pkg::out_word_t               result;
    drpt_pkg::core_status_t            status;
    logic [drpt_pkg::COORD_W-1:0]      last_x;
    logic [drpt_pkg::COORD_W-1:0]      last_y;
    logic [drpt_pkg::TICK_W-1:0]       idle_limit;

    drpt_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .last_x     (last_x),
        .last_y     (last_y),
        .idle_limit (idle_limit)
    );

    drpt_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s1_adv),
        .word       (s1_word_reg),
        .last_x     (last_x),
        .last_y     (last_y),
        .idle_limit (idle_limit),
        .has_result (has_result),
        .result     (result),
        .status     (status)
    );

    // The held word moves on whenever the result register is free or draining.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    assign s1_valid_next  = (in_valid && in_ready) || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv ? has_result : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_word_reg <= in_data;
        end
        if (s1_adv && has_result)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    `DRPT_ASSERT_NOW(a_full_from_origin, clk, rst_n,
        out_valid_reg && out_word_reg.full_refresh,
        (out_word_reg.copy_x0 == '0) && (out_word_reg.copy_y0 == '0))
    `DRPT_ASSERT_NEXT(a_full_clears_state, clk, rst_n,
        s1_adv && has_result && result.full_refresh,
        !status.force_pending && !status.dirty)
    `DRPT_ASSERT_NEXT(a_held_word_kept, clk, rst_n,
        s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_word_reg))
    `DRPT_ASSERT_NOW(a_result_needs_present, clk, rst_n,
        s1_adv && has_result, s1_word_reg.cmd == drpt_pkg::CMD_PRESENT)

endmodule

`default_nettype wire

// File: rtl/drpt_cfg.sv
// Configuration registers of the dirty rectangle tracker and the derived
// last column and row of the screen. Depends on drpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drpt_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [drpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [drpt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic      [drpt_pkg::COORD_W-1:0]       last_x,
    output logic      [drpt_pkg::COORD_W-1:0]       last_y,
    output logic      [drpt_pkg::TICK_W-1:0]        idle_limit
);

    logic [drpt_pkg::DIM_REG_W-1:0] width_reg;
    logic [drpt_pkg::DIM_REG_W-1:0] width_next;
    logic [drpt_pkg::DIM_REG_W-1:0] height_reg;
    logic [drpt_pkg::DIM_REG_W-1:0] height_next;
    logic [drpt_pkg::TICK_W-1:0]    limit_reg;
    logic [drpt_pkg::TICK_W-1:0]    limit_next;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        limit_next  = limit_reg;
        if (cfg_wr_en)
        begin
            case (drpt_pkg::cfg_reg_t'(cfg_index))
                drpt_pkg::REG_SCREEN_WIDTH:
                    width_next = cfg_wdata[drpt_pkg::DIM_REG_W-1:0];
                drpt_pkg::REG_SCREEN_HEIGHT:
                    height_next = cfg_wdata[drpt_pkg::DIM_REG_W-1:0];
                drpt_pkg::REG_IDLE_FULL_LIMIT:
                    limit_next = cfg_wdata[drpt_pkg::TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= drpt_pkg::WIDTH_RESET;
            height_reg <= drpt_pkg::HEIGHT_RESET;
            limit_reg  <= drpt_pkg::LIMIT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            limit_reg  <= limit_next;
        end
    end

    assign last_x     = drpt_pkg::dim_last(width_reg);
    assign last_y     = drpt_pkg::dim_last(height_reg);
    assign idle_limit = limit_reg;

endmodule

`default_nettype wire

// File: rtl/drpt_core.sv
// Tracker state (dirty box, force flag, last present time) and the per-word
// decode of mark, force and present commands. Depends on drpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drpt_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire drpt_pkg::in_word_t             word,
    input  wire logic [drpt_pkg::COORD_W-1:0]   last_x,
    input  wire logic [drpt_pkg::COORD_W-1:0]   last_y,
    input  wire logic [drpt_pkg::TICK_W-1:0]    idle_limit,
    output logic                                has_result,
    output drpt_pkg::out_word_t                 result,
    output drpt_pkg::core_status_t              status
);

    localparam int CW = drpt_pkg::COORD_W;
    localparam int EW = drpt_pkg::EXT_W;
    localparam int RW = drpt_pkg::RECT_W;

    logic                              dirty_reg;
    logic                              dirty_next;
    logic                              force_reg;
    logic                              force_next;
    logic [CW-1:0]                     min_x_reg;
    logic [CW-1:0]                     min_x_next;
    logic [CW-1:0]                     min_y_reg;
    logic [CW-1:0]                     min_y_next;
    logic [CW-1:0]                     max_x_reg;
    logic [CW-1:0]                     max_x_next;
    logic [CW-1:0]                     max_y_reg;
    logic [CW-1:0]                     max_y_next;
    logic [drpt_pkg::TICK_W-1:0]       last_time_reg;
    logic [drpt_pkg::TICK_W-1:0]       last_time_next;

    logic signed [EW-1:0] x_ext;
    logic signed [EW-1:0] y_ext;
    logic signed [EW-1:0] x_end;
    logic signed [EW-1:0] y_end;
    logic                 rect_ok;
    logic [CW-1:0]        cx0;
    logic [CW-1:0]        cy0;
    logic [CW-1:0]        cx1;
    logic [CW-1:0]        cy1;
    logic                 do_mark;
    logic [drpt_pkg::TICK_W-1:0] gap;
    logic                 full;

    // The far corner is formed two bits wider than the inputs so it cannot wrap.
    assign x_ext = EW'(word.rect_x);
    assign y_ext = EW'(word.rect_y);
    assign x_end = x_ext + EW'(word.rect_w) - EW'(signed'(1));
    assign y_end = y_ext + EW'(word.rect_h) - EW'(signed'(1));
    assign rect_ok = (word.rect_w > RW'(signed'(0))) && (word.rect_h > RW'(signed'(0)));

    // A force marks the whole screen through the same widen path as a mark.
    always_comb
    begin
        if (word.cmd == drpt_pkg::CMD_FORCE)
        begin
            cx0 = '0;
            cy0 = '0;
            cx1 = last_x;
            cy1 = last_y;
        end
        else
        begin
            cx0 = drpt_pkg::clamp_coord(x_ext, last_x);
            cy0 = drpt_pkg::clamp_coord(y_ext, last_y);
            cx1 = drpt_pkg::clamp_coord(x_end, last_x);
            cy1 = drpt_pkg::clamp_coord(y_end, last_y);
        end
    end

    assign gap  = word.tick_count - last_time_reg;
    assign full = force_reg || ((idle_limit != '0) && (gap > idle_limit));

    always_comb
    begin
        do_mark = 1'b0;
        case (word.cmd)
            drpt_pkg::CMD_MARK:    do_mark = rect_ok;
            drpt_pkg::CMD_FORCE:   do_mark = 1'b1;
            drpt_pkg::CMD_PRESENT: do_mark = 1'b0;
            default:               do_mark = 1'b0;
        endcase
    end

    always_comb
    begin
        dirty_next     = dirty_reg;
        force_next     = force_reg;
        min_x_next     = min_x_reg;
        min_y_next     = min_y_reg;
        max_x_next     = max_x_reg;
        max_y_next     = max_y_reg;
        last_time_next = last_time_reg;
        has_result     = 1'b0;
        result         = '0;

        if (word.cmd == drpt_pkg::CMD_FORCE)
        begin
            force_next = 1'b1;
        end

        if (do_mark)
        begin
            dirty_next = 1'b1;
            if (!dirty_reg)
            begin
                min_x_next = cx0;
                min_y_next = cy0;
                max_x_next = cx1;
                max_y_next = cy1;
            end
            else
            begin
                if (cx0 < min_x_reg) min_x_next = cx0;
                if (cy0 < min_y_reg) min_y_next = cy0;
                if (cx1 > max_x_reg) max_x_next = cx1;
                if (cy1 > max_y_reg) max_y_next = cy1;
            end
        end

        if (word.cmd == drpt_pkg::CMD_PRESENT)
        begin
            if (full)
            begin
                has_result          = 1'b1;
                result.full_refresh = 1'b1;
                result.copy_x1      = last_x;
                result.copy_y1      = last_y;
                dirty_next          = 1'b0;
                force_next          = 1'b0;
                last_time_next      = word.tick_count;
            end
            else if (dirty_reg)
            begin
                has_result     = 1'b1;
                result.copy_x0 = min_x_reg;
                result.copy_y0 = min_y_reg;
                result.copy_x1 = max_x_reg;
                result.copy_y1 = max_y_reg;
                dirty_next     = 1'b0;
                last_time_next = word.tick_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg     <= 1'b1;
            force_reg     <= 1'b1;
            min_x_reg     <= '0;
            min_y_reg     <= '0;
            max_x_reg     <= drpt_pkg::dim_last(drpt_pkg::WIDTH_RESET);
            max_y_reg     <= drpt_pkg::dim_last(drpt_pkg::HEIGHT_RESET);
            last_time_reg <= '0;
        end
        else if (advance)
        begin
            dirty_reg     <= dirty_next;
            force_reg     <= force_next;
            min_x_reg     <= min_x_next;
            min_y_reg     <= min_y_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
            last_time_reg <= last_time_next;
        end
    end

    assign status.dirty         = dirty_reg;
    assign status.force_pending = force_reg;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for dirty_rect_present_tracker: a queue-fed driver, a monitor and
// a predictor of the dirty box, checked over several screen and idle-limit settings.
// Depends on drpt_pkg and the RTL of the tracker.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    drpt_pkg::in_word_t              in_data   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    drpt_pkg::out_word_t             out_data;
    logic                            cfg_wr_en = 1'b0;
    logic [drpt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [drpt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Register copies and tracker state as the bench predicts them.
    logic [12:0] scr_w      = 13'd640;
    logic [12:0] scr_h      = 13'd480;
    logic [31:0] idle_limit = '0;
    bit          box_dirty  = 1'b1;
    logic [11:0] box_x0     = 12'd0;
    logic [11:0] box_y0     = 12'd0;
    logic [11:0] box_x1     = 12'd639;
    logic [11:0] box_y1     = 12'd479;
    bit          full_due   = 1'b1;
    logic [31:0] last_tick  = '0;

    drpt_pkg::in_word_t  word_queue[$];
    drpt_pkg::out_word_t region_q[$];
    logic [31:0] tick_now      = '0;
    bit          calm          = 1'b0;
    int          gap_left      = 0;
    int          stall_left    = 0;
    int          quiet_cycles  = 0;
    int          words_sent    = 0;
    int          regions_seen  = 0;
    int          full_seen     = 0;
    int          fail_count    = 0;

    dirty_rect_present_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Last usable coordinate for a dimension register; 0 acts as 1, big values saturate.
    function automatic logic [11:0] eff_last(input logic [12:0] r);
        int d;
        d = int'(r);
        if (d < 1) d = 1;
        if (d > drpt_pkg::MAX_DIM) d = drpt_pkg::MAX_DIM;
        return 12'(d - 1);
    endfunction

    function automatic logic [11:0] clip(input int v, input int last);
        if (v < 0) return 12'd0;
        if (v > last) return 12'(last);
        return 12'(v);
    endfunction

    function automatic void mark_area(input int x, input int y, input int w, input int h);
        int          lx;
        int          ly;
        logic [11:0] a0;
        logic [11:0] b0;
        logic [11:0] a1;
        logic [11:0] b1;
        lx = int'(eff_last(scr_w));
        ly = int'(eff_last(scr_h));
        if (w <= 0 || h <= 0) return;
        a0 = clip(x, lx);
        b0 = clip(y, ly);
        a1 = clip(x + w - 1, lx);
        b1 = clip(y + h - 1, ly);
        if (!box_dirty)
        begin
            box_dirty = 1'b1;
            box_x0 = a0;
            box_y0 = b0;
            box_x1 = a1;
            box_y1 = b1;
            return;
        end
        if (a0 < box_x0) box_x0 = a0;
        if (b0 < box_y0) box_y0 = b0;
        if (a1 > box_x1) box_x1 = a1;
        if (b1 > box_y1) box_y1 = b1;
    endfunction

    // Advances the predicted state by one accepted word and queues any region it yields.
    function automatic void predict_word(input drpt_pkg::in_word_t wd);
        drpt_pkg::out_word_t r;
        logic [31:0]         gap;
        bit                  full;
        r = '0;
        gap = wd.tick_count - last_tick;
        case (wd.cmd)
            drpt_pkg::CMD_MARK:
                mark_area($signed(wd.rect_x), $signed(wd.rect_y),
                          $signed(wd.rect_w), $signed(wd.rect_h));
            drpt_pkg::CMD_FORCE:
            begin
                full_due = 1'b1;
                mark_area(0, 0, int'(eff_last(scr_w)) + 1, int'(eff_last(scr_h)) + 1);
            end
            drpt_pkg::CMD_PRESENT:
            begin
                full = full_due || (idle_limit != 0 && gap > idle_limit);
                if (full)
                begin
                    r.full_refresh = 1'b1;
                    r.copy_x1 = eff_last(scr_w);
                    r.copy_y1 = eff_last(scr_h);
                    box_dirty = 1'b0;
                    full_due = 1'b0;
                    last_tick = wd.tick_count;
                    region_q.push_back(r);
                end
                else if (box_dirty)
                begin
                    r.copy_x0 = box_x0;
                    r.copy_y0 = box_y0;
                    r.copy_x1 = box_x1;
                    r.copy_y1 = box_y1;
                    box_dirty = 1'b0;
                    last_tick = wd.tick_count;
                    region_q.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic drpt_pkg::in_word_t make_word(input logic [1:0] c, input int x,
                                                     input int y, input int w, input int h,
                                                     input logic [31:0] t);
        drpt_pkg::in_word_t wd;
        wd.cmd = drpt_pkg::cmd_t'(c);
        wd.rect_x = 16'(x);
        wd.rect_y = 16'(y);
        wd.rect_w = 16'(w);
        wd.rect_h = 16'(h);
        wd.tick_count = t;
        return wd;
    endfunction

    // Mostly on-screen marks and presents with a moving tick count, plus noise.
    function automatic drpt_pkg::in_word_t rand_item();
        int sw;
        int sh;
        int pick;
        int x;
        int y;
        sw = int'(eff_last(scr_w)) + 1;
        sh = int'(eff_last(scr_h)) + 1;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            x = $urandom_range(0, sw + 16);
            y = $urandom_range(0, sh + 16);
            return make_word(drpt_pkg::CMD_MARK, x - 8, y - 8,
                             $urandom_range(1, sw / 2 + 2),
                             $urandom_range(1, sh / 2 + 2), $urandom);
        end
        if (pick < 55)
            return make_word(drpt_pkg::CMD_MARK, $urandom, $urandom, $urandom, $urandom,
                             $urandom);
        if (pick < 60)
            return make_word(drpt_pkg::CMD_MARK, $urandom_range(0, 1) ? 32767 : -32768,
                             $urandom_range(0, 1) ? 32767 : -32768, 32767, 32767, $urandom);
        if (pick < 70)
            return make_word(drpt_pkg::CMD_FORCE, $urandom, $urandom, $urandom, $urandom,
                             $urandom);
        if (pick < 95)
        begin
            case ($urandom_range(0, 3))
                0: tick_now += $urandom_range(0, 2);
                1: tick_now += $urandom_range(0, 150);
                2: tick_now += $urandom_range(0, 1500);
                default: tick_now = $urandom;
            endcase
            return make_word(drpt_pkg::CMD_PRESENT, $urandom, $urandom, $urandom, $urandom,
                             tick_now);
        end
        return make_word(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Driver: loads the next word once the current one is taken, with random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_word(in_data);
                words_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_queue.size() > 0)
                begin
                    in_data <= word_queue.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 10);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each region word against the oldest prediction, stalls at random.
    always @(posedge clk)
    begin
        drpt_pkg::out_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (region_q.size() == 0)
                begin
                    $error("region word with nothing expected: %h", out_data);
                    fail_count++;
                end
                else
                begin
                    want = region_q.pop_front();
                    regions_seen++;
                    if (out_data.full_refresh) full_seen++;
                    if (out_data.full_refresh !== want.full_refresh)
                    begin
                        $error("full_refresh: expected %0d, actual %0d",
                               want.full_refresh, out_data.full_refresh);
                        fail_count++;
                    end
                    if (out_data.copy_x0 !== want.copy_x0)
                    begin
                        $error("copy_x0: expected %0d, actual %0d",
                               want.copy_x0, out_data.copy_x0);
                        fail_count++;
                    end
                    if (out_data.copy_y0 !== want.copy_y0)
                    begin
                        $error("copy_y0: expected %0d, actual %0d",
                               want.copy_y0, out_data.copy_y0);
                        fail_count++;
                    end
                    if (out_data.copy_x1 !== want.copy_x1)
                    begin
                        $error("copy_x1: expected %0d, actual %0d",
                               want.copy_x1, out_data.copy_x1);
                        fail_count++;
                    end
                    if (out_data.copy_y1 !== want.copy_y1)
                    begin
                        $error("copy_y1: expected %0d, actual %0d",
                               want.copy_y1, out_data.copy_y1);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Waits until every word is taken and every region has come, then lets marks drain.
    task automatic settle();
        @(negedge clk);
        while (word_queue.size() != 0 || in_valid || region_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input drpt_pkg::cfg_reg_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            drpt_pkg::REG_SCREEN_WIDTH:  scr_w = val[12:0];
            drpt_pkg::REG_SCREEN_HEIGHT: scr_h = val[12:0];
            default:                     idle_limit = val;
        endcase
    endtask

    task automatic set_screen(input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] lim);
        settle();
        write_reg(drpt_pkg::REG_SCREEN_WIDTH, w);
        write_reg(drpt_pkg::REG_SCREEN_HEIGHT, h);
        write_reg(drpt_pkg::REG_IDLE_FULL_LIMIT, lim);
    endtask

    task automatic push_random(input int n);
        repeat (n) word_queue.push_back(rand_item());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset screen of 640x480 with the idle limit off.
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, 0, 0, 0, 0, 32'd5));
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, 0, 0, 0, 0, 32'd6));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, 10, 20, 30, 40, 0));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, -100, -100, 50, 50, 0));
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, 0, 0, 0, 0, 32'd7));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, 32767, 32767, 32767, 32767, 0));
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, 0, 0, 0, 0, 32'd8));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, 600, 400, -5, 10, 0));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, 0, 0, 0, 0, 0));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, -32768, -32768, -32768, -32768,
                                       0));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, 5, 5, 10, 0, 0));
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, 0, 0, 0, 0, 32'd9));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, -32768, -32768, 1, 1, 0));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, 639, 0, 1, 1, 0));
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, 0, 0, 0, 0, 32'd10));
        word_queue.push_back(make_word(drpt_pkg::CMD_FORCE, -1, -1, -1, -1, 32'hFFFF_FFFF));
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, -1, -1, -1, -1,
                                       32'hFFFF_FFFF));
        word_queue.push_back(make_word(CMD_UNUSED, -1, -1, -1, -1, 32'hFFFF_FFFF));
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, 0, 0, 0, 0, 32'd0));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, 100, 100, 1, 1, 0));
        word_queue.push_back(make_word(CMD_UNUSED, 0, 0, 0, 0, 0));
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, 0, 0, 0, 0, 32'd1));

        // Largest screen; leave a mark behind so the next, smaller screen sees an old box.
        set_screen(32'd4096, 32'd4096, 32'd0);
        push_random(60);
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, 0, 0, 0, 0, tick_now));
        word_queue.push_back(make_word(drpt_pkg::CMD_MARK, 3000, 3000, 10, 10, 0));

        set_screen(32'd1, 32'd1, 32'd0);
        word_queue.push_back(make_word(drpt_pkg::CMD_PRESENT, 0, 0, 0, 0, tick_now));
        push_random(40);

        // Zero dimensions act as one; short idle limit.
        set_screen(32'd0, 32'd0, 32'd100);
        push_random(60);

        // Oversized dimensions saturate; a limit no tick gap can exceed.
        set_screen(32'd8191, 32'd5000, 32'hFFFF_FFFF);
        push_random(60);

        set_screen({19'h7FFFF, 13'd321}, 32'd200, 32'd1000);
        push_random(60);

        settle();
        calm = 1'b1;
        set_screen(32'd640, 32'd480, 32'd50);
        push_random(100);

        settle();
        repeat (10) @(posedge clk);
        $display("covered %0d words in and %0d regions out, %0d of them full refreshes,",
                 words_sent, regions_seen, full_seen);
        $display("over six screen and idle-limit settings plus the reset one");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/drpt_pkg.sv
rtl/drpt_cfg.sv
rtl/drpt_core.sv
rtl/dirty_rect_present_tracker.sv
tb/tb_top.sv
